// ===== rtl/core/sint2dec_pkg.sv =====
// Package for the signed integer to decimal ASCII converter.
// Holds widths, character codes and the controller/datapath command and status words.
// Used by sint2dec_ctrl, sint2dec_dp and signed_int_to_decimal_ascii_core.
package sint2dec_pkg;

  // Width of the value port and the number of low bits that are converted
  localparam int VALUE_W    = 32;
  localparam int VALUE_BITS = 32;

  // Decimal digits needed for a magnitude of up to 2^(VALUE_BITS-1)
  localparam int DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int BCD_W  = DIGITS * 4;
  localparam int PTR_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  localparam int CHAR_W = 6;

  // ASCII codes, trimmed to the character field width
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] CHAR_NINE  = CHAR_W'(57);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic shift;
    logic find;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic negative;
    logic conv_last;
    logic ptr_zero;
  } stat_t;

endpackage

// ===== rtl/core/sint2dec_dp.sv =====
// Datapath of the signed integer to decimal ASCII converter.
// Holds magnitude, BCD digits (double dabble), digit pointer and the output word registers.
// Depends on sint2dec_pkg.
module sint2dec_dp
  import sint2dec_pkg::*;
(
  input  logic               clk,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [VALUE_W-1:0] value,
  output logic [CHAR_W-1:0]  character,
  output logic               last
);

  logic [VALUE_BITS-1:0] mag;
  logic [BCD_W-1:0]      bcd;
  logic [CNT_W-1:0]      count;
  logic [PTR_W-1:0]      ptr;
  logic                  negative;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] abs_val;
  logic [BCD_W-1:0]      bcd_adj;
  logic [PTR_W-1:0]      lead;
  logic [3:0]            digit;

  // Take the low bits and form the unsigned magnitude
  assign raw     = value[VALUE_BITS-1:0];
  assign abs_val = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  // Locate the most significant nonzero digit; zero keeps the ones digit
  always_comb begin
    lead = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        lead = PTR_W'(i);
      end
    end
  end

  assign digit = bcd[ptr*4 +: 4];

  // Load, convert, then walk the digits from the top
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag      <= abs_val;
      bcd      <= '0;
      count    <= '0;
      negative <= raw[VALUE_BITS-1];
    end
    if (cmd.shift) begin
      bcd   <= {bcd_adj[BCD_W-2:0], mag[VALUE_BITS-1]};
      mag   <= {mag[VALUE_BITS-2:0], 1'b0};
      count <= count + CNT_W'(1);
    end
    if (cmd.find) begin
      ptr <= lead;
    end
    if (cmd.emit_sign) begin
      character <= CHAR_MINUS;
      last      <= 1'b0;
    end
    if (cmd.emit_digit) begin
      character <= CHAR_ZERO + {{(CHAR_W-4){1'b0}}, digit};
      last      <= (ptr == '0);
      ptr       <= ptr - PTR_W'(1);
    end
  end

  assign stat.negative  = negative;
  assign stat.conv_last = (count == CNT_W'(VALUE_BITS - 1));
  assign stat.ptr_zero  = (ptr == '0);

endmodule

// ===== rtl/core/sint2dec_ctrl.sv =====
// Controller of the signed integer to decimal ASCII converter.
// Sequences load, conversion, digit search and word emission; drives busy and strobe.
// Depends on sint2dec_pkg.
module sint2dec_ctrl
  import sint2dec_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  strobe
);

  typedef enum logic [2:0] {
    IDLE,
    CONVERT,
    FIND,
    SIGN,
    DIGIT
  } state_t;

  state_t state;
  state_t state_next;

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = CONVERT;
        end
      end
      CONVERT: begin
        cmd.shift = 1'b1;
        if (stat.conv_last) begin
          state_next = FIND;
        end
      end
      FIND: begin
        cmd.find   = 1'b1;
        state_next = stat.negative ? SIGN : DIGIT;
      end
      SIGN: begin
        cmd.emit_sign = 1'b1;
        state_next    = DIGIT;
      end
      DIGIT: begin
        cmd.emit_digit = 1'b1;
        if (stat.ptr_zero) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // Hold state and the registered strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= cmd.emit_sign | cmd.emit_digit;
    end
  end

  assign busy = (state != IDLE);

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE && start) |=> (state == CONVERT))
    else $error("accepted word did not start conversion");

  a_sign_only_negative: assert property (@(posedge clk) disable iff (rst)
    (state == SIGN) |-> stat.negative)
    else $error("minus emitted for a non-negative value");

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ($past(state) == SIGN || $past(state) == DIGIT))
    else $error("strobe without an emit cycle");

  a_find_after_convert: assert property (@(posedge clk) disable iff (rst)
    (state == FIND) |-> ($past(state) == CONVERT))
    else $error("digit search entered out of order");

endmodule

// ===== rtl/core/signed_int_to_decimal_ascii_core.sv =====
// Signed integer to decimal ASCII converter, top level.
// Instantiates sint2dec_ctrl and sint2dec_dp; depends on sint2dec_pkg.
//
// Usage:
//   Input: drive value and raise start; the word is taken at a rising edge where
//   start is high and busy is low. busy stays high until the last character
//   has been issued.
//   Output: each character appears on character/last for exactly one cycle with
//   strobe high, most significant first; a leading minus precedes negative
//   values, zero gives a single '0', and last marks the final character.
//   The receiver cannot stall the block; it must take every strobed word.
// Sequence:
//   After acceptance the double-dabble loop runs one shift per bit, a search
//   step locates the leading digit, then one character is issued per cycle
//   (1 to 11 characters). A new word is taken only once the controller has
//   returned to idle with the final character.
// Reset:
//   rst is synchronous and active high; it returns the controller to idle and
//   drops strobe. A conversion in progress is abandoned.
module signed_int_to_decimal_ascii_core
  import sint2dec_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] value,
  output logic               strobe,
  output logic [CHAR_W-1:0]  character,
  output logic               last
);

  cmd_t  cmd;
  stat_t stat;

  sint2dec_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  sint2dec_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .stat      (stat),
    .value     (value),
    .character (character),
    .last      (last)
  );

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("word strobed right after the final character");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (character == CHAR_MINUS ||
                (character >= CHAR_ZERO && character <= CHAR_NINE)))
    else $error("character outside minus and digit codes");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for signed_int_to_decimal_ascii_core: converts signed words to decimal text.
// Predicts each character, compares strobed output in order; depends on sint2dec_pkg.
module tb_top;
  import sint2dec_pkg::*;

  localparam int RANDOM_WORDS  = 350;
  localparam int QUIET_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 60;

  // One expected output character
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              is_last;
  } text_char_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [VALUE_W-1:0] value = '0;
  logic               busy;
  logic               strobe;
  logic [CHAR_W-1:0]  character;
  logic               last;

  logic [VALUE_W-1:0] pending_words[$];
  text_char_t         expected_text[$];

  int error_count = 0;
  int words_converted = 0;
  int negatives_converted = 0;
  int chars_checked = 0;
  int longest_text = 0;
  int quiet_cycles = 0;
  int gap_left = 0;
  int burst_left = 0;

  signed_int_to_decimal_ascii_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

  // Free-running clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Queue the decimal text of one word, sign first, most significant digit next
  function automatic void push_decimal_text(input logic [VALUE_W-1:0] word);
    logic [VALUE_W-1:0] magnitude;
    logic [3:0]         digits[0:15];
    int                 count;
    int                 k;
    text_char_t         ch;
    magnitude = word[VALUE_W-1] ? (~word + 1'b1) : word;
    count = 0;
    do begin
      digits[count] = 4'(magnitude % 10);
      count++;
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (word[VALUE_W-1]) begin
      ch.code = CHAR_MINUS;
      ch.is_last = 1'b0;
      expected_text.push_back(ch);
      negatives_converted++;
    end
    for (k = count - 1; k >= 0; k--) begin
      ch.code = CHAR_ZERO + CHAR_W'(digits[k]);
      ch.is_last = (k == 0);
      expected_text.push_back(ch);
    end
    if (count + word[VALUE_W-1] > longest_text) longest_text = count + word[VALUE_W-1];
  endfunction

  // Draw a word with a chosen number of decimal digits and a random sign
  function automatic logic [VALUE_W-1:0] random_sized_word();
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned mag;
    n = $urandom_range(1, 10);
    lo = 1;
    repeat (n - 1) lo = lo * 10;
    hi = (n == 10) ? 32'd2147483647 : lo * 10 - 1;
    if (n == 1) lo = 0;
    mag = $urandom_range(lo, hi);
    if ($urandom_range(0, 1)) begin
      if (n == 10 && $urandom_range(0, 15) == 0) mag = 32'h8000_0000;
      return ~mag + 1'b1;
    end
    return mag;
  endfunction

  // Driver: offer the oldest pending word, hold it until taken, then idle a while
  always @(posedge clk) begin
    logic taken;
    if (rst) begin
      start <= 1'b0;
      value <= '0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        push_decimal_text(value);
        words_converted++;
        void'(pending_words.pop_front());
        if (burst_left > 0) begin
          burst_left--;
          gap_left = 0;
        end else begin
          gap_left = $urandom_range(0, 19);
          if ($urandom_range(0, 24) == 0) burst_left = $urandom_range(5, 20);
        end
      end
      if (start && !taken) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
        value <= $urandom;
      end else if (pending_words.size() > 0) begin
        start <= 1'b1;
        value <= pending_words[0];
      end else begin
        start <= 1'b0;
        value <= $urandom;
      end
    end
  end

  // Monitor: check every strobed character against the oldest expectation
  always @(posedge clk) begin
    text_char_t want;
    if (!rst && strobe) begin
      chars_checked++;
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual code %0d last %0b",
                 $time, character, last);
        error_count++;
      end else begin
        want = expected_text.pop_front();
        if (character !== want.code) begin
          $display("%0t: character mismatch: expected %0d, actual %0d",
                   $time, want.code, character);
          error_count++;
        end
        if (last !== want.is_last) begin
          $display("%0t: last flag mismatch: expected %0b, actual %0b",
                   $time, want.is_last, last);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout after %0d quiet cycles", quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    // Directed words: zero, small and digit-boundary values, both extremes
    pending_words.push_back(32'd0);
    pending_words.push_back(32'd1);
    pending_words.push_back(-32'sd1);
    pending_words.push_back(32'd9);
    pending_words.push_back(32'd10);
    pending_words.push_back(-32'sd10);
    pending_words.push_back(32'd99);
    pending_words.push_back(32'd100);
    pending_words.push_back(-32'sd1000);
    pending_words.push_back(32'd1000000);
    pending_words.push_back(32'd999999999);
    pending_words.push_back(-32'sd999999999);
    pending_words.push_back(32'd1000000000);
    pending_words.push_back(32'd123456789);
    pending_words.push_back(-32'sd123456789);
    pending_words.push_back(32'h7FFF_FFFF);
    pending_words.push_back(32'h8000_0000);
    pending_words.push_back(32'h8000_0001);
    pending_words.push_back(32'h5555_5555);
    pending_words.push_back(32'hAAAA_AAAA);
    // Random words: mostly chosen by digit count, the rest raw bit patterns
    repeat (RANDOM_WORDS) begin
      if ($urandom_range(0, 3) == 0) pending_words.push_back($urandom);
      else pending_words.push_back(random_sized_word());
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Drain: all words taken, all characters seen, then a quiet tail
    while (pending_words.size() > 0 || expected_text.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d words (%0d negative), checked %0d characters, longest text %0d",
             words_converted, negatives_converted, chars_checked, longest_text);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Mismatches found: %0d", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
